// ----- hw/rtl/fifo_with_remove_by_key_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyed-removal FIFO
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_REMOVE_BY_KEY_ASSERT_SVH
`define FIFO_WITH_REMOVE_BY_KEY_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FWRK_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion %m failed");
`define FWRK_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion %m failed");
`define FWRK_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion %m failed");
`else
`define FWRK_ASSERT_ALWAYS(name, expr)
`define FWRK_ASSERT_IMPL(name, ante, cons)
`define FWRK_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ----- hw/rtl/fwrk_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyed-removal FIFO package
// Sizes, codes, record and result types shared by the FIFO modules.
// ----------------------------------------------------------------------------
package fwrk_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int MODE_W = 2;
	localparam int REF_W  = 32;
	localparam int AMT_W  = 31;
	localparam int PAY_W  = 64;
	localparam int STAT_W = 2;
	localparam int OCNT_W = 5;
	localparam int TOT_W  = 35;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT    = 2'd0,
		MODE_GET    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_GET   = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_SHIFT = 4'b1000
	} state_t;

	typedef struct packed {
		logic [REF_W-1:0] key;
		logic [AMT_W-1:0] amount;
		logic [PAY_W-1:0] payload;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic              valid;
		status_t           status;
		rec_t              rec;
		logic [OCNT_W-1:0] count;
		logic [TOT_W-1:0]  total;
	} res_t;

	// Maps a position counted from the head to a physical entry of the ring.
	function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
			input logic [ADDR_W-1:0] idx);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + {1'b0, idx};
		if (sum >= (ADDR_W + 1)'(DEPTH)) begin
			sum = sum - (ADDR_W + 1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/fwrk_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fwrk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/fwrk_seq.sv -----
// ----------------------------------------------------------------------------
// Keyed-removal FIFO sequencer
// Ring pointers, totals and the scan and shift walk over the record memory.
// ----------------------------------------------------------------------------
`include "fifo_with_remove_by_key_assert.svh"

module fwrk_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fwrk_pkg::MODE_W-1:0]     mode,
	input  logic [fwrk_pkg::REF_W-1:0]      reference,
	input  logic [fwrk_pkg::AMT_W-1:0]      amount,
	input  logic [fwrk_pkg::PAY_W-1:0]      payload,
	output logic                            busy,
	output logic                            wr_en,
	output logic [fwrk_pkg::ADDR_W-1:0]     wr_addr,
	output fwrk_pkg::rec_t                  wr_data,
	output logic                            rd_en,
	output logic [fwrk_pkg::ADDR_W-1:0]     rd_addr,
	input  fwrk_pkg::rec_t                  rd_data,
	output fwrk_pkg::res_t                  res
);

	fwrk_pkg::state_t                state_q, state_d;
	logic [fwrk_pkg::ADDR_W-1:0]     head_q, head_d;
	logic [fwrk_pkg::CNT_W-1:0]      count_q, count_d;
	logic [fwrk_pkg::TOT_W-1:0]      total_q, total_d;
	logic [fwrk_pkg::ADDR_W-1:0]     idx_q, idx_d;
	logic [fwrk_pkg::REF_W-1:0]      ref_q, ref_d;
	fwrk_pkg::rec_t                  found_q, found_d;

	logic                            full;
	logic                            empty;
	logic                            scan_last;
	logic                            shift_last;
	logic                            shift_done;
	logic [fwrk_pkg::ADDR_W-1:0]     idx_inc;
	logic [fwrk_pkg::ADDR_W-1:0]     idx_inc2;

	assign full       = count_q == fwrk_pkg::CNT_W'(fwrk_pkg::DEPTH);
	assign empty      = count_q == '0;
	assign scan_last  = (fwrk_pkg::CNT_W'(idx_q) + fwrk_pkg::CNT_W'(1)) == count_q;
	assign shift_last = (fwrk_pkg::CNT_W'(idx_q) + fwrk_pkg::CNT_W'(2)) == count_q;
	assign shift_done = (state_q == fwrk_pkg::ST_SHIFT) && shift_last;
	assign idx_inc    = idx_q + fwrk_pkg::ADDR_W'(1);
	assign idx_inc2   = idx_q + fwrk_pkg::ADDR_W'(2);
	assign busy       = state_q != fwrk_pkg::ST_IDLE;

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		total_d = total_q;
		idx_d   = idx_q;
		ref_d   = ref_q;
		found_d = found_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		res     = '0;
		res.status = fwrk_pkg::STAT_OK;
		unique case (state_q)
			fwrk_pkg::ST_IDLE: begin
				if (start) begin
					ref_d = reference;
					idx_d = '0;
					unique case (fwrk_pkg::mode_t'(mode))
						fwrk_pkg::MODE_PUT: begin
							res.valid = 1'b1;
							if (full) begin
								res.status = fwrk_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = fwrk_pkg::phys_addr(head_q,
									fwrk_pkg::ADDR_W'(count_q));
								wr_data = {reference, amount, payload};
								count_d = count_q + fwrk_pkg::CNT_W'(1);
								total_d = total_q + fwrk_pkg::TOT_W'(amount);
							end
						end
						fwrk_pkg::MODE_GET: begin
							if (empty) begin
								res.valid  = 1'b1;
								res.status = fwrk_pkg::STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								state_d = fwrk_pkg::ST_GET;
							end
						end
						fwrk_pkg::MODE_REMOVE: begin
							if (empty) begin
								res.valid  = 1'b1;
								res.status = fwrk_pkg::STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								state_d = fwrk_pkg::ST_SCAN;
							end
						end
						fwrk_pkg::MODE_QUERY: begin
							res.valid = 1'b1;
						end
					endcase
				end
			end
			fwrk_pkg::ST_GET: begin
				res.valid = 1'b1;
				res.rec   = rd_data;
				head_d    = fwrk_pkg::phys_addr(head_q, fwrk_pkg::ADDR_W'(1));
				count_d   = count_q - fwrk_pkg::CNT_W'(1);
				total_d   = total_q - fwrk_pkg::TOT_W'(rd_data.amount);
				state_d   = fwrk_pkg::ST_IDLE;
			end
			fwrk_pkg::ST_SCAN: begin
				if (rd_data.key == ref_q) begin
					found_d = rd_data;
					total_d = total_q - fwrk_pkg::TOT_W'(rd_data.amount);
					if (scan_last) begin
						count_d   = count_q - fwrk_pkg::CNT_W'(1);
						res.valid = 1'b1;
						res.rec   = rd_data;
						state_d   = fwrk_pkg::ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = fwrk_pkg::phys_addr(head_q, idx_inc);
						state_d = fwrk_pkg::ST_SHIFT;
					end
				end else if (scan_last) begin
					res.valid  = 1'b1;
					res.status = fwrk_pkg::STAT_EMPTY;
					state_d    = fwrk_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = fwrk_pkg::phys_addr(head_q, idx_inc);
					idx_d   = idx_inc;
				end
			end
			fwrk_pkg::ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = fwrk_pkg::phys_addr(head_q, idx_q);
				wr_data = rd_data;
				if (shift_last) begin
					count_d   = count_q - fwrk_pkg::CNT_W'(1);
					res.valid = 1'b1;
					res.rec   = found_q;
					state_d   = fwrk_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = fwrk_pkg::phys_addr(head_q, idx_inc2);
					idx_d   = idx_inc;
				end
			end
			default: begin
				state_d = fwrk_pkg::ST_IDLE;
			end
		endcase
		res.count = fwrk_pkg::OCNT_W'(count_d);
		res.total = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwrk_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		ref_q   <= ref_d;
		found_q <= found_d;
	end

	`FWRK_ASSERT_ALWAYS(a_count_bound, count_q <= fwrk_pkg::CNT_W'(fwrk_pkg::DEPTH))
	`FWRK_ASSERT_IMPL(a_empty_total, count_q == '0, total_q == '0)
	`FWRK_ASSERT_IMPL(a_finish_reports, busy && (state_d == fwrk_pkg::ST_IDLE), res.valid)
	`FWRK_ASSERT_IMPL(a_full_status, res.valid && (res.status == fwrk_pkg::STAT_FULL), full)
	`FWRK_ASSERT_NEXT(a_shift_shrinks, shift_done, count_q == $past(count_q) - fwrk_pkg::CNT_W'(1))

endmodule

// ----- hw/rtl/fifo_with_remove_by_key.sv -----
// ----------------------------------------------------------------------------
// Keyed-removal FIFO
// Ordered queue of records with put, get, remove by key and query.
//
// Channel   Handshake          Fields
// input     start, busy        mode, reference, amount, payload
// result    done (strobe)      status, out_reference, out_amount, out_payload,
//                              entry_count, amount_total
//
// Put, query, and get or remove on an empty queue report in the cycle after they
// are taken; busy stays low for them, so they can follow back to back.
// Get on a non-empty queue reports from the get state, through the result register.
// Remove walks the queue from the head and reports when the walk ends, found or
// not: the scan and the shift of the later records use one read per record.
// Reset clears the count and the total; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module fifo_with_remove_by_key (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [fwrk_pkg::MODE_W-1:0] mode,
	input  logic [fwrk_pkg::REF_W-1:0]  reference,
	input  logic [fwrk_pkg::AMT_W-1:0]  amount,
	input  logic [fwrk_pkg::PAY_W-1:0]  payload,
	output logic                        done,
	output logic [fwrk_pkg::STAT_W-1:0] status,
	output logic [fwrk_pkg::REF_W-1:0]  out_reference,
	output logic [fwrk_pkg::AMT_W-1:0]  out_amount,
	output logic [fwrk_pkg::PAY_W-1:0]  out_payload,
	output logic [fwrk_pkg::OCNT_W-1:0] entry_count,
	output logic [fwrk_pkg::TOT_W-1:0]  amount_total
);

	logic                          wr_en;
	logic [fwrk_pkg::ADDR_W-1:0]   wr_addr;
	fwrk_pkg::rec_t                wr_data;
	logic                          rd_en;
	logic [fwrk_pkg::ADDR_W-1:0]   rd_addr;
	fwrk_pkg::rec_t                rd_data;
	fwrk_pkg::res_t                res;

	logic                          done_q;
	fwrk_pkg::res_t                res_q;

	fwrk_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.reference (reference),
		.amount    (amount),
		.payload   (payload),
		.busy      (busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res       (res)
	);

	fwrk_ram #(
		.WIDTH (fwrk_pkg::REC_W),
		.DEPTH (fwrk_pkg::DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			res_q <= res;
		end
	end

	assign done          = done_q;
	assign status        = res_q.status;
	assign out_reference = res_q.rec.key;
	assign out_amount    = res_q.rec.amount;
	assign out_payload   = res_q.rec.payload;
	assign entry_count   = res_q.count;
	assign amount_total  = res_q.total;

endmodule
